>>> hw/rtl/pnghdr_pkg.sv
// Shared types and constants for the PNG header info parser.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package pnghdr_pkg;

  // Chunk walker phases
  typedef enum logic [2:0] {
    PH_SIG,
    PH_LEN,
    PH_TYPE,
    PH_SKIP,
    PH_PHYS,
    PH_DONE
  } phase_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_SIG,
    ST_BAD_IHDR,
    ST_TRUNC
  } status_t;

  // Where the reported dpi comes from
  typedef enum logic [1:0] {
    DPI_ZERO,
    DPI_DEFAULT,
    DPI_PHYS
  } dpi_src_t;

  // File signature, first byte in the top bits
  localparam logic [63:0] SIG_BYTES  = 64'h8950_4E47_0D0A_1A0A;
  localparam logic [31:0] TYPE_IHDR  = 32'h4948_4452;
  localparam logic [31:0] TYPE_PHYS  = 32'h7048_5973;

  // File positions of the header fields
  localparam logic [4:0] POS_SIG_LAST = 5'd7;
  localparam logic [4:0] POS_IHDR     = 5'd12;
  localparam logic [4:0] POS_WIDTH    = 5'd16;
  localparam logic [4:0] POS_HEIGHT   = 5'd20;
  localparam logic [4:0] POS_DEPTH    = 5'd24;
  localparam logic [4:0] POS_COLOUR   = 5'd25;
  localparam logic [4:0] HEADER_END   = 5'd26;

  localparam logic [3:0] FIELD_BYTES  = 4'd4;
  localparam logic [3:0] PHYS_BYTES   = 4'd9;
  localparam logic [7:0] UNIT_METRE   = 8'd1;
  localparam logic [7:0] DEPTH_8      = 8'd8;
  localparam logic [7:0] COLOUR_RGBA  = 8'd6;
  localparam logic [5:0] PIX_BITS_RGBA = 6'd32;
  localparam logic [5:0] PIX_BITS_DFLT = 6'd24;
  localparam logic [15:0] DEFAULT_DPI_RST = 16'd300;

  // dpi = floor((ppm*254 + 5000) / 10000). 10000 = 16 * 625: shift by 4,
  // then divide by 625 in two 18-bit digits, each by reciprocal multiply.
  localparam logic [7:0]  DPI_MUL  = 8'd254;
  localparam logic [12:0] DPI_BIAS = 13'd5000;
  localparam logic [9:0]  DPI_DIV  = 10'd625;
  localparam logic [18:0] RECIP_HI = 19'd429497;      // ceil(2^28 / 625)
  localparam logic [28:0] RECIP_LO = 29'd439804652;   // ceil(2^38 / 625)

  // Values the parser hands over at the end of a file
  typedef struct packed {
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] ppm_x;
    logic [31:0] ppm_y;
    logic [15:0] dflt;
    dpi_src_t    src;
    logic [5:0]  pixel_bits;
    status_t     status;
  } hdr_sum_t;

  // Same without the pixels-per-metre, carried beside the dpi divider
  typedef struct packed {
    logic [31:0] width;
    logic [31:0] height;
    logic [15:0] dflt;
    dpi_src_t    src;
    logic [5:0]  pixel_bits;
    status_t     status;
  } hdr_meta_t;

  // Signature byte at file position idx
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [2:0] inv;
    inv = 3'd7 - idx;
    return SIG_BYTES[{inv, 3'b000} +: 8];
  endfunction

  // IHDR type byte at offset idx within the type field
  function automatic logic [7:0] ihdr_byte(input logic [1:0] idx);
    logic [1:0] inv;
    inv = 2'd3 - idx;
    return TYPE_IHDR[{inv, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pnghdr_parse.sv
// Byte-wise PNG parser: signature/IHDR checks, header capture, chunk walk.
// Depends on pnghdr_pkg. Produces a summary for the byte marked last.
`default_nettype none

module pnghdr_parse (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic [7:0]            file_byte,
  input  wire logic                  last_byte,
  input  wire logic [15:0]           default_dpi,
  output pnghdr_pkg::hdr_sum_t       summary
);
  import pnghdr_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  byte_index, byte_index_next;
  logic [4:0]  file_pos, file_pos_next;
  logic [32:0] chunk_remaining, chunk_remaining_next;
  logic [31:0] chunk_length_shift, chunk_length_shift_next;
  logic [31:0] chunk_type_shift, chunk_type_shift_next;
  logic [31:0] width_reg, width_reg_next;
  logic [31:0] height_reg, height_reg_next;
  logic [7:0]  bit_depth_reg, bit_depth_reg_next;
  logic [7:0]  colour_type_reg, colour_type_reg_next;
  logic [31:0] ppu_x_reg, ppu_x_reg_next;
  logic [31:0] ppu_y_reg, ppu_y_reg_next;
  logic [7:0]  unit_reg, unit_reg_next;
  logic        found_phys, found_phys_next;
  status_t     status_reg, status_reg_next;

  // Next state for one accepted byte
  always_comb begin
    status_t     st_hdr;
    logic [3:0]  bi_inc;
    logic [31:0] type_new;
    logic [32:0] rem_dec;
    phase_next              = phase;
    byte_index_next         = byte_index;
    file_pos_next           = file_pos;
    chunk_remaining_next    = chunk_remaining;
    chunk_length_shift_next = chunk_length_shift;
    chunk_type_shift_next   = chunk_type_shift;
    width_reg_next          = width_reg;
    height_reg_next         = height_reg;
    bit_depth_reg_next      = bit_depth_reg;
    colour_type_reg_next    = colour_type_reg;
    ppu_x_reg_next          = ppu_x_reg;
    ppu_y_reg_next          = ppu_y_reg;
    unit_reg_next           = unit_reg;
    found_phys_next         = found_phys;
    status_reg_next         = status_reg;
    st_hdr   = ST_OK;
    bi_inc   = byte_index + 4'd1;
    type_new = {chunk_type_shift[23:0], file_byte};
    rem_dec  = (chunk_remaining != 33'd0) ? chunk_remaining - 33'd1 : chunk_remaining;
    if (status_reg == ST_OK) begin
      // Fixed header fields by file position
      if (file_pos <= POS_SIG_LAST) begin
        if (file_byte != sig_byte(file_pos[2:0])) st_hdr = ST_BAD_SIG;
      end else if (file_pos >= POS_IHDR && file_pos < POS_WIDTH) begin
        if (file_byte != ihdr_byte(file_pos[1:0])) st_hdr = ST_BAD_IHDR;
      end else if (file_pos >= POS_WIDTH && file_pos < POS_HEIGHT) begin
        width_reg_next = {width_reg[23:0], file_byte};
      end else if (file_pos >= POS_HEIGHT && file_pos < POS_DEPTH) begin
        height_reg_next = {height_reg[23:0], file_byte};
      end else if (file_pos == POS_DEPTH) begin
        bit_depth_reg_next = file_byte;
      end else if (file_pos == POS_COLOUR) begin
        colour_type_reg_next = file_byte;
      end
      status_reg_next = st_hdr;

      // Chunk walk
      if (st_hdr == ST_OK) begin
        case (phase)
          PH_SIG: begin
            if (file_pos == POS_SIG_LAST) begin
              phase_next      = PH_LEN;
              byte_index_next = 4'd0;
            end
          end
          PH_LEN: begin
            chunk_length_shift_next = {chunk_length_shift[23:0], file_byte};
            byte_index_next         = bi_inc;
            if (bi_inc >= FIELD_BYTES) begin
              phase_next      = PH_TYPE;
              byte_index_next = 4'd0;
            end
          end
          PH_TYPE: begin
            chunk_type_shift_next = type_new;
            byte_index_next       = bi_inc;
            if (bi_inc >= FIELD_BYTES) begin
              byte_index_next = 4'd0;
              if (type_new == TYPE_PHYS) begin
                phase_next = PH_PHYS;
              end else begin
                chunk_remaining_next = {1'b0, chunk_length_shift} + 33'd4;
                phase_next           = PH_SKIP;
              end
            end
          end
          PH_SKIP: begin
            chunk_remaining_next = rem_dec;
            if (rem_dec == 33'd0) begin
              phase_next      = PH_LEN;
              byte_index_next = 4'd0;
            end
          end
          PH_PHYS: begin
            if (byte_index < 4'd4) begin
              ppu_x_reg_next = {ppu_x_reg[23:0], file_byte};
            end else if (byte_index < 4'd8) begin
              ppu_y_reg_next = {ppu_y_reg[23:0], file_byte};
            end else begin
              unit_reg_next = file_byte;
            end
            byte_index_next = bi_inc;
            if (bi_inc >= PHYS_BYTES) begin
              found_phys_next = 1'b1;
              phase_next      = PH_DONE;
              byte_index_next = 4'd0;
            end
          end
          default: begin
          end
        endcase
      end else begin
        phase_next = PH_DONE;
      end

      if (file_pos < HEADER_END) file_pos_next = file_pos + 5'd1;
    end
  end

  // Summary as seen after the last byte
  always_comb begin
    logic    trunc;
    status_t st_fin;
    trunc = (file_pos_next < HEADER_END) || (phase_next == PH_TYPE) ||
            (phase_next == PH_PHYS) ||
            ((phase_next == PH_LEN) && (byte_index_next != 4'd0));
    st_fin = (status_reg_next == ST_OK && trunc) ? ST_TRUNC : status_reg_next;
    summary.status = st_fin;
    summary.ppm_x  = ppu_x_reg_next;
    summary.ppm_y  = ppu_y_reg_next;
    summary.dflt   = default_dpi;
    if (st_fin == ST_OK) begin
      summary.width      = width_reg_next;
      summary.height     = height_reg_next;
      summary.pixel_bits = (bit_depth_reg_next == DEPTH_8 &&
                            colour_type_reg_next == COLOUR_RGBA) ?
                           PIX_BITS_RGBA : PIX_BITS_DFLT;
      summary.src        = (found_phys_next && unit_reg_next == UNIT_METRE) ?
                           DPI_PHYS : DPI_DEFAULT;
    end else begin
      summary.width      = 32'd0;
      summary.height     = 32'd0;
      summary.pixel_bits = PIX_BITS_DFLT;
      summary.src        = DPI_ZERO;
    end
  end

  // State registers; the last byte of a file clears everything
  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      phase              <= PH_SIG;
      byte_index         <= 4'd0;
      file_pos           <= 5'd0;
      chunk_remaining    <= 33'd0;
      chunk_length_shift <= 32'd0;
      chunk_type_shift   <= 32'd0;
      width_reg          <= 32'd0;
      height_reg         <= 32'd0;
      bit_depth_reg      <= 8'd0;
      colour_type_reg    <= 8'd0;
      ppu_x_reg          <= 32'd0;
      ppu_y_reg          <= 32'd0;
      unit_reg           <= 8'd0;
      found_phys         <= 1'b0;
      status_reg         <= ST_OK;
    end else if (accept) begin
      phase              <= phase_next;
      byte_index         <= byte_index_next;
      file_pos           <= file_pos_next;
      chunk_remaining    <= chunk_remaining_next;
      chunk_length_shift <= chunk_length_shift_next;
      chunk_type_shift   <= chunk_type_shift_next;
      width_reg          <= width_reg_next;
      height_reg         <= height_reg_next;
      bit_depth_reg      <= bit_depth_reg_next;
      colour_type_reg    <= colour_type_reg_next;
      ppu_x_reg          <= ppu_x_reg_next;
      ppu_y_reg          <= ppu_y_reg_next;
      unit_reg           <= unit_reg_next;
      found_phys         <= found_phys_next;
      status_reg         <= status_reg_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pnghdr_dpi.sv
// Pipelined pixels-per-metre to dpi conversion, floor((ppm*254+5000)/10000).
// Depends on pnghdr_pkg. Three register stages; quotient leaves combinationally.
`default_nettype none

module pnghdr_dpi (
  input  wire logic        clk,
  input  wire logic [2:0]  en,
  input  wire logic [31:0] ppm,
  output logic      [26:0] dpi
);
  import pnghdr_pkg::*;

  logic [39:0] scaled;
  logic [35:0] x_q;
  logic [36:0] prod_hi;
  logic [8:0]  qh_c;
  logic [8:0]  qh_q, qh2_q;
  logic [17:0] xh_q, xl_q;
  logic [17:0] qh_times_d;
  logic [17:0] rem_hi;
  logic [27:0] y_q;
  logic [56:0] prod_lo;

  // Scale and bias, then drop the factor 16 of the divisor
  assign scaled = 40'(ppm) * 40'(DPI_MUL) + 40'(DPI_BIAS);

  // Upper digit quotient by reciprocal
  assign prod_hi = 37'(x_q[35:18]) * 37'(RECIP_HI);
  assign qh_c    = prod_hi[36:28];

  // Upper digit remainder, joined with the lower digit
  assign qh_times_d = 18'(qh_q) * 18'(DPI_DIV);
  assign rem_hi     = xh_q - qh_times_d;

  // Lower digit quotient by reciprocal
  assign prod_lo = 57'(y_q) * 57'(RECIP_LO);
  assign dpi     = {qh2_q, prod_lo[55:38]};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_q <= scaled[39:4];
    end
    if (en[1]) begin
      qh_q <= qh_c;
      xh_q <= x_q[35:18];
      xl_q <= x_q[17:0];
    end
    if (en[2]) begin
      y_q   <= {rem_hi[9:0], xl_q};
      qh2_q <= qh_q;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/png_header_info_parser.sv
// PNG header info parser. Takes one file byte per transfer on s_axis (tlast on
// the final byte) and may take a byte every cycle. The byte marked last yields
// one result on m_axis, passed through a summary register loaded with that byte,
// three stages of the dpi divider (two digits of a reciprocal multiply by 625)
// and the output register. Each stage holds only while the one after it is full
// and stalled, so bytes keep flowing while a result waits; the input stalls only
// once all five stages hold results. cfg_data sets the default dpi.
// Depends on pnghdr_pkg, pnghdr_parse and pnghdr_dpi.
`default_nettype none

module png_header_info_parser (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,    // [7:0] file_byte
  input  wire logic         s_axis_tlast,    // last_byte
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [127:0] m_axis_tdata,    // [31:0] image_width, [63:32] image_height,
                                             // [90:64] dpi_horizontal,
                                             // [117:91] dpi_vertical,
                                             // [123:118] pixel_bits,
                                             // [125:124] parse_status, [127:126] zero
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [15:0]  cfg_data         // default_dpi
);
  import pnghdr_pkg::*;

  logic        accept;
  logic [15:0] default_dpi;
  hdr_sum_t    summary;
  hdr_sum_t    s1;
  hdr_meta_t   s2, s3, s4;
  logic [5:1]  vld;
  logic [5:1]  rdy;
  logic [26:0] dpi_x_c, dpi_y_c;
  logic [26:0] dpi_x_sel, dpi_y_sel;
  logic [31:0] out_width, out_height;
  logic [26:0] out_dpi_x, out_dpi_y;
  logic [5:0]  out_pixel_bits;
  status_t     out_status;

  assign cfg_ready = 1'b1;

  // Default dpi register
  always_ff @(posedge clk) begin
    if (rst) begin
      default_dpi <= DEFAULT_DPI_RST;
    end else if (cfg_valid) begin
      default_dpi <= cfg_data;
    end
  end

  // Stage handshakes: a stage loads when it is empty or its successor moves
  assign rdy[5] = !vld[5] || m_axis_tready;
  assign rdy[4] = !vld[4] || rdy[5];
  assign rdy[3] = !vld[3] || rdy[4];
  assign rdy[2] = !vld[2] || rdy[3];
  assign rdy[1] = !vld[1] || rdy[2];

  assign s_axis_tready = rdy[1];
  assign accept        = s_axis_tvalid && rdy[1];

  pnghdr_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .file_byte   (s_axis_tdata),
    .last_byte   (s_axis_tlast),
    .default_dpi (default_dpi),
    .summary     (summary)
  );

  pnghdr_dpi u_dpi_x (
    .clk (clk),
    .en  (rdy[4:2]),
    .ppm (s1.ppm_x),
    .dpi (dpi_x_c)
  );

  pnghdr_dpi u_dpi_y (
    .clk (clk),
    .en  (rdy[4:2]),
    .ppm (s1.ppm_y),
    .dpi (dpi_y_c)
  );

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= accept && s_axis_tlast;
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
      if (rdy[4]) vld[4] <= vld[3];
      if (rdy[5]) vld[5] <= vld[4];
    end
  end

  // dpi source selection
  always_comb begin
    case (s4.src)
      DPI_PHYS: begin
        dpi_x_sel = dpi_x_c;
        dpi_y_sel = dpi_y_c;
      end
      DPI_DEFAULT: begin
        dpi_x_sel = 27'(s4.dflt);
        dpi_y_sel = 27'(s4.dflt);
      end
      default: begin
        dpi_x_sel = 27'd0;
        dpi_y_sel = 27'd0;
      end
    endcase
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (rdy[1]) s1 <= summary;
    if (rdy[2]) begin
      s2.width      <= s1.width;
      s2.height     <= s1.height;
      s2.dflt       <= s1.dflt;
      s2.src        <= s1.src;
      s2.pixel_bits <= s1.pixel_bits;
      s2.status     <= s1.status;
    end
    if (rdy[3]) s3 <= s2;
    if (rdy[4]) s4 <= s3;
    if (rdy[5]) begin
      out_width      <= s4.width;
      out_height     <= s4.height;
      out_dpi_x      <= dpi_x_sel;
      out_dpi_y      <= dpi_y_sel;
      out_pixel_bits <= s4.pixel_bits;
      out_status     <= s4.status;
    end
  end

  assign m_axis_tvalid = vld[5];
  assign m_axis_tdata  = {2'b00, out_status, out_pixel_bits, out_dpi_y, out_dpi_x,
                          out_height, out_width};

endmodule

`default_nettype wire

>>> hw/rtl/pnghdr_chk.sv
// Port-level checker for png_header_info_parser, bound to the top level.
// Depends on pnghdr_pkg for the status and pixel-size codes.
`default_nettype none

module pnghdr_chk (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [127:0] m_axis_tdata
);
  import pnghdr_pkg::*;

  logic [1:0] status_f;
  logic [5:0] pix_f;

  assign status_f = m_axis_tdata[125:124];
  assign pix_f    = m_axis_tdata[123:118];

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // No result straight out of reset
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // Error results carry zeros and the default pixel size
  a_err: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && status_f != ST_OK |->
      m_axis_tdata[117:0] == 118'd0 && pix_f == PIX_BITS_DFLT)
    else $error("error result carries data");

  // Pixel size is one of the two codes
  a_pix: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pix_f == PIX_BITS_DFLT || pix_f == PIX_BITS_RGBA)
    else $error("bad pixel size");

endmodule

bind png_header_info_parser pnghdr_chk u_pnghdr_chk (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> dv/png_header_info_parser_tb.sv
// Self-checking testbench for png_header_info_parser: PNG byte streams in,
// one header summary out per file, checked against a scoreboard predictor.
// Depends on pnghdr_pkg and the png_header_info_parser RTL.
`default_nettype none

module png_header_info_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pnghdr_pkg::*;

  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
  localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;
  localparam int          HOLD_CYCLES = 300;
  localparam int          SETTLE_CYCLES = 8;

  // Expected summary, packed like m_axis_tdata (top bits first)
  typedef struct packed {
    logic [1:0]  pad;
    status_t     status;
    logic [5:0]  pixel_bits;
    logic [26:0] dpi_v;
    logic [26:0] dpi_h;
    logic [31:0] height;
    logic [31:0] width;
  } hdr_summary_t;

  // Predicts one summary per file and checks what the block returns
  class hdr_scoreboard;
    logic [15:0]  default_dpi;
    phase_t       walk_phase;
    int unsigned  field_idx;
    int unsigned  file_pos;
    logic [32:0]  skip_left;
    logic [31:0]  len_sr, type_sr, width, height, ppm_x, ppm_y;
    logic [7:0]   depth, colour, unit;
    bit           phys_seen;
    status_t      status;
    hdr_summary_t summaries_q[$];
    int unsigned  failures;
    int unsigned  results_seen;

    function new();
      default_dpi  = DEFAULT_DPI_RST;
      failures     = 0;
      results_seen = 0;
      clear_file();
    endfunction

    function void clear_file();
      walk_phase = PH_SIG;
      field_idx  = 0;
      file_pos   = 0;
      skip_left  = '0;
      len_sr     = '0;
      type_sr    = '0;
      width      = '0;
      height     = '0;
      ppm_x      = '0;
      ppm_y      = '0;
      depth      = '0;
      colour     = '0;
      unit       = '0;
      phys_seen  = 1'b0;
      status     = ST_OK;
    endfunction

    // Exact rounding of ppm * 0.0254
    function logic [26:0] ppm_to_dpi(logic [31:0] ppm);
      logic [63:0] wide;
      wide = (64'(ppm) * 64'(DPI_MUL) + 64'(DPI_BIAS)) / 64'd10000;
      return wide[26:0];
    endfunction

    // One accepted byte; a summary is due when it is the last of the file
    function void take_byte(logic [7:0] b, logic last);
      status_t      st;
      hdr_summary_t s;
      if (status == ST_OK) begin
        // fixed header fields by file position
        if (file_pos <= POS_SIG_LAST) begin
          if (b != SIG_BYTES[(7 - file_pos) * 8 +: 8]) status = ST_BAD_SIG;
        end else if (file_pos >= POS_IHDR && file_pos < POS_WIDTH) begin
          if (b != TYPE_IHDR[(15 - file_pos) * 8 +: 8]) status = ST_BAD_IHDR;
        end else if (file_pos >= POS_WIDTH && file_pos < POS_HEIGHT) begin
          width = {width[23:0], b};
        end else if (file_pos >= POS_HEIGHT && file_pos < POS_DEPTH) begin
          height = {height[23:0], b};
        end else if (file_pos == POS_DEPTH) begin
          depth = b;
        end else if (file_pos == POS_COLOUR) begin
          colour = b;
        end
        // chunk walk, stopped by the first error
        if (status != ST_OK) begin
          walk_phase = PH_DONE;
        end else begin
          case (walk_phase)
            PH_SIG: begin
              if (file_pos == POS_SIG_LAST) begin
                walk_phase = PH_LEN;
                field_idx  = 0;
              end
            end
            PH_LEN: begin
              len_sr = {len_sr[23:0], b};
              field_idx++;
              if (field_idx >= FIELD_BYTES) begin
                walk_phase = PH_TYPE;
                field_idx  = 0;
              end
            end
            PH_TYPE: begin
              type_sr = {type_sr[23:0], b};
              field_idx++;
              if (field_idx >= FIELD_BYTES) begin
                field_idx = 0;
                if (type_sr == TYPE_PHYS) begin
                  walk_phase = PH_PHYS;
                end else begin
                  skip_left  = {1'b0, len_sr} + 33'd4;
                  walk_phase = PH_SKIP;
                end
              end
            end
            PH_SKIP: begin
              if (skip_left != 0) skip_left--;
              if (skip_left == 0) begin
                walk_phase = PH_LEN;
                field_idx  = 0;
              end
            end
            PH_PHYS: begin
              if (field_idx < 4) ppm_x = {ppm_x[23:0], b};
              else if (field_idx < 8) ppm_y = {ppm_y[23:0], b};
              else unit = b;
              field_idx++;
              if (field_idx >= PHYS_BYTES) begin
                phys_seen  = 1'b1;
                walk_phase = PH_DONE;
                field_idx  = 0;
              end
            end
            default: ;
          endcase
        end
        if (file_pos < HEADER_END) file_pos++;
      end
      if (!last) return;

      // ending inside a header, chunk head or pHYs body is truncation
      st = status;
      if (st == ST_OK && (file_pos < HEADER_END || walk_phase == PH_TYPE ||
                          walk_phase == PH_PHYS ||
                          (walk_phase == PH_LEN && field_idx != 0)))
        st = ST_TRUNC;

      s = '0;
      s.status = st;
      s.pixel_bits = PIX_BITS_DFLT;
      if (st == ST_OK) begin
        s.width  = width;
        s.height = height;
        if (phys_seen && unit == UNIT_METRE) begin
          s.dpi_h = ppm_to_dpi(ppm_x);
          s.dpi_v = ppm_to_dpi(ppm_y);
        end else begin
          s.dpi_h = 27'(default_dpi);
          s.dpi_v = 27'(default_dpi);
        end
        if (depth == DEPTH_8 && colour == COLOUR_RGBA) s.pixel_bits = PIX_BITS_RGBA;
      end
      summaries_q.push_back(s);
      clear_file();
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        failures++;
        if (failures <= 10)
          $display("summary %0d: %s expected 0x%0h got 0x%0h",
                   results_seen, name, want, got);
      end
    endfunction

    // One accepted result transfer against the oldest expected summary
    function void check_summary(logic [127:0] got);
      hdr_summary_t want;
      results_seen++;
      if (summaries_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("summary %0d: none expected, got 0x%032h", results_seen, got);
        return;
      end
      want = summaries_q.pop_front();
      compare_field("image_width", want.width, got[31:0]);
      compare_field("image_height", want.height, got[63:32]);
      compare_field("dpi_horizontal", 32'(want.dpi_h), 32'(got[90:64]));
      compare_field("dpi_vertical", 32'(want.dpi_v), 32'(got[117:91]));
      compare_field("pixel_bits", 32'(want.pixel_bits), 32'(got[123:118]));
      compare_field("parse_status", 32'(want.status), 32'(got[125:124]));
      compare_field("pad", 32'(want.pad), 32'(got[127:126]));
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;    // [7:0] file_byte
  logic         s_axis_tlast = 1'b0;  // last_byte
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;         // [31:0] width, [63:32] height, [90:64] dpi_h,
                                      // [117:91] dpi_v, [123:118] pixel_bits,
                                      // [125:124] parse_status, [127:126] zero
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;        // default_dpi

  hdr_scoreboard hdr_sb;
  bit            idle_on = 1'b1;
  bit            hold_req = 1'b0;
  logic [7:0]    file_bytes[$];

  png_header_info_parser dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Transfer monitor on both streams
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) hdr_sb.check_summary(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) hdr_sb.take_byte(s_axis_tdata, s_axis_tlast);
    end
  end

  // Result receiver: random backpressure, or one long hold when asked
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_axis_tready <= !(idle_on && $urandom_range(99) < 30);
      end
    end
  end

  // File builders
  function automatic void put_be32(logic [31:0] v);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(v[i * 8 +: 8]);
  endfunction

  function automatic void put_random(int unsigned n);
    repeat (n) file_bytes.push_back(8'($urandom_range(255)));
  endfunction

  // Signature plus an IHDR chunk, always 13 data bytes whatever the length says
  function automatic void begin_file(logic [31:0] w, logic [31:0] h, logic [7:0] bd,
                                     logic [7:0] ct, logic [31:0] ihdr_len);
    file_bytes.delete();
    for (int i = 0; i < 8; i++) file_bytes.push_back(SIG_BYTES[(7 - i) * 8 +: 8]);
    put_be32(ihdr_len);
    put_be32(TYPE_IHDR);
    put_be32(w);
    put_be32(h);
    file_bytes.push_back(bd);
    file_bytes.push_back(ct);
    put_random(3 + 4);
  endfunction

  function automatic void put_chunk(logic [31:0] len, logic [31:0] typ, int unsigned ndata);
    put_be32(len);
    put_be32(typ);
    put_random(ndata + 4);
  endfunction

  function automatic void put_phys(int unsigned len, logic [31:0] px, logic [31:0] py,
                                   logic [7:0] u);
    put_be32(len);
    put_be32(TYPE_PHYS);
    put_be32(px);
    put_be32(py);
    file_bytes.push_back(u);
    put_random(((len > 9) ? len - 9 : 0) + 4);
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(20000));
      default: return $urandom();
    endcase
  endfunction

  // Random file, mostly well formed; returns a cut length or 0 for whole
  function automatic int build_random_file();
    int          kind, idx;
    logic [7:0]  bd, ct, u;
    int unsigned len;
    kind = $urandom_range(99);
    bd = $urandom_range(1) ? DEPTH_8 : 8'($urandom_range(255));
    ct = $urandom_range(1) ? COLOUR_RGBA : 8'($urandom_range(255));
    begin_file(pick32(), pick32(), bd, ct,
               ($urandom_range(9) == 0) ? 32'($urandom_range(20)) : 32'd13);
    if (kind < 12) begin
      // huge chunk, the file ends somewhere in its skipped data
      put_chunk($urandom_range(1) ? 32'hFFFF_FFFF : (32'h8000_0000 | $urandom()),
                $urandom(), $urandom_range(12));
      return 0;
    end
    repeat ($urandom_range(2)) begin
      len = $urandom_range(6);
      put_chunk(len, $urandom(), len);
    end
    if ($urandom_range(99) < 65) begin
      idx = $urandom_range(99);
      u = (idx < 70) ? UNIT_METRE : (idx < 85) ? 8'd0 : 8'($urandom_range(255));
      put_phys(($urandom_range(3) == 0) ? $urandom_range(12) : 9, pick32(), pick32(), u);
      if ($urandom_range(1)) put_chunk(2, $urandom(), 2);
    end
    put_chunk(0, TYPE_IEND, 0);
    if (kind >= 80 && kind < 90) begin
      // corrupt a signature or IHDR type byte
      idx = $urandom_range(1) ? $urandom_range(7) : $urandom_range(15, 12);
      file_bytes[idx] ^= 8'($urandom_range(255, 1));
    end else if (kind >= 90) begin
      file_bytes.delete();
      put_random($urandom_range(40, 1));
    end
    return ($urandom_range(3) == 0) ? $urandom_range(file_bytes.size(), 1) : 0;
  endfunction

  // Byte sender with random gaps
  task automatic send_byte(input logic [7:0] b, input logic l);
    if (idle_on && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Sends the built file, or its first cut bytes, tlast on the final one
  task automatic send_file(input int cut);
    int n;
    n = (cut <= 0 || cut > file_bytes.size()) ? file_bytes.size() : cut;
    for (int i = 0; i < n; i++) send_byte(file_bytes[i], i == n - 1);
  endtask

  // Sender pauses until every expected summary has come back
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (hdr_sb.summaries_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dpi(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    hdr_sb.default_dpi = v;
  endtask

  initial begin : stimulus
    int          phase_bytes, phase_files, cut;
    logic [15:0] dpi_setting;
    hdr_sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed files, default dpi still at its reset value
    // extreme sizes, RGBA, largest ppm in metres
    begin_file(32'hFFFF_FFFF, 32'h0, DEPTH_8, COLOUR_RGBA, 13);
    put_phys(9, 32'hFFFF_FFFF, 32'h0, UNIT_METRE);
    put_chunk(0, TYPE_IEND, 0);
    send_file(0);
    // a skipped chunk before pHYs, RGB so 24 bits
    begin_file(32'h0, 32'hFFFF_FFFF, DEPTH_8, 8'd2, 13);
    put_chunk(3, TYPE_TEXT, 3);
    put_phys(9, 32'd11811, 32'd5905, UNIT_METRE);
    put_chunk(0, TYPE_IEND, 0);
    send_file(0);
    // unit not metre gives the default
    begin_file(32'd640, 32'd480, 8'd16, COLOUR_RGBA, 13);
    put_phys(9, 32'd11811, 32'd11811, 8'd0);
    put_chunk(0, TYPE_IEND, 0);
    send_file(0);
    // no pHYs at all, ends on a chunk boundary
    begin_file(32'd1, 32'd1, DEPTH_8, COLOUR_RGBA, 13);
    put_chunk(2, TYPE_TEXT, 2);
    put_chunk(0, TYPE_IEND, 0);
    send_file(0);
    // pHYs declaring zero length still reads nine bytes; rest ignored
    begin_file(32'd77, 32'd99, DEPTH_8, 8'd0, 13);
    put_phys(0, 32'd3779, 32'd3780, UNIT_METRE);
    put_chunk(0, TYPE_IEND, 0);
    send_file(0);
    // bad signature, then bad IHDR type
    begin_file(32'd5, 32'd5, DEPTH_8, COLOUR_RGBA, 13);
    file_bytes[0] = 8'h00;
    send_file(0);
    begin_file(32'd5, 32'd5, DEPTH_8, COLOUR_RGBA, 13);
    file_bytes[15] ^= 8'h20;
    put_chunk(0, TYPE_IEND, 0);
    send_file(0);
    // early ends: one byte, one short of the header, header exactly,
    // inside a chunk length, inside a type, inside pHYs, on a boundary
    begin_file(32'd9, 32'd9, DEPTH_8, COLOUR_RGBA, 13);
    put_phys(9, 32'd2835, 32'd2835, UNIT_METRE);
    send_file(1);
    send_file(25);
    send_file(26);
    send_file(35);
    send_file(39);
    send_file(45);
    send_file(33);
    // huge chunk length, file ends in its data
    begin_file(32'd3, 32'd4, DEPTH_8, COLOUR_RGBA, 13);
    put_chunk(32'hFFFF_FFFF, TYPE_TEXT, 6);
    send_file(0);
    wait_drain();

    // Random phases, each under a new default dpi
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: dpi_setting = 16'h0000;
        1: dpi_setting = 16'hFFFF;
        3: dpi_setting = DEFAULT_DPI_RST;
        default: dpi_setting = 16'($urandom_range(65535));
      endcase
      write_dpi(dpi_setting);
      idle_on = (p != 2);
      if (p == 3) begin
        // receiver holds off while short files pile up behind it
        hold_req = 1'b1;
        repeat (16) begin
          if ($urandom_range(1)) begin_file(pick32(), pick32(), DEPTH_8, COLOUR_RGBA, 13);
          else begin
            file_bytes.delete();
            put_random(4);
          end
          send_file($urandom_range(4, 1));
        end
      end
      phase_bytes = 0;
      phase_files = 0;
      while (phase_bytes < 30 || phase_files < 1) begin
        cut = build_random_file();
        phase_bytes += (cut != 0) ? cut : file_bytes.size();
        phase_files++;
        send_file(cut);
      end
      wait_drain();
    end

    if (hdr_sb.failures == 0) begin
      $display("png_header_info_parser regression: pass");
    end else begin
      $display("png_header_info_parser regression: fail");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #(5_000_000);
    $display("png_header_info_parser regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
